>>> rtl/acr3d_pkg.sv
// ----------------------------------------------------------------------------
// acr3d_pkg
// Shared widths, beat types and helpers for the 3D box collision resolver.
// ----------------------------------------------------------------------------
package acr3d_pkg;

    localparam int COORD_W       = 24;
    localparam int EXT_W         = COORD_W - 1;
    localparam int THR_W         = EXT_W;
    localparam int REST_W        = 9;
    localparam int REST_FRAC     = 8;
    localparam int OVL_W         = COORD_W + 2;
    localparam int WIDE_W        = COORD_W + REST_W + 2;
    localparam int FRAC_BITS_DEF = 8;
    localparam int AXIS_W        = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic signed [COORD_W-1:0] vel_z;
        logic [EXT_W-1:0]          extent_xz;
        logic [EXT_W-1:0]          extent_y;
        logic                      is_fixed;
        logic [REST_W-1:0]         restitution;
    } t_in_beat;

    typedef struct packed {
        logic                      body_index;
        logic                      collided;
        logic signed [COORD_W-1:0] new_pos_x;
        logic signed [COORD_W-1:0] new_pos_y;
        logic signed [COORD_W-1:0] new_pos_z;
        logic signed [COORD_W-1:0] new_vel_x;
        logic signed [COORD_W-1:0] new_vel_y;
        logic signed [COORD_W-1:0] new_vel_z;
        logic                      last;
    } t_out_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic signed [COORD_W-1:0] vel_z;
        logic [EXT_W-1:0]          extent_xz;
        logic [EXT_W-1:0]          extent_y;
        logic                      fixed;
        logic [REST_W-1:0]         restitution;
    } t_body;

    typedef struct packed {
        t_out_beat beat0;
        t_out_beat beat1;
    } t_pair;

    function automatic t_body body_of(input t_in_beat b);
        t_body r;
        r.pos_x       = b.pos_x;
        r.pos_y       = b.pos_y;
        r.pos_z       = b.pos_z;
        r.vel_x       = b.vel_x;
        r.vel_y       = b.vel_y;
        r.vel_z       = b.vel_z;
        r.extent_xz   = b.extent_xz;
        r.extent_y    = b.extent_y;
        r.fixed       = b.is_fixed;
        r.restitution = b.restitution;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] x
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed({{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
        lo = ~hi;
        if (x > hi) begin
            return hi[COORD_W-1:0];
        end else if (x < lo) begin
            return lo[COORD_W-1:0];
        end
        return x[COORD_W-1:0];
    endfunction

endpackage

>>> rtl/acr3d_resolve.sv
// ----------------------------------------------------------------------------
// acr3d_resolve
// Overlap test, axis choice, push-apart and velocity bounce for one pair.
// ----------------------------------------------------------------------------
module acr3d_resolve
    import acr3d_pkg::*;
(
    input  t_body            i_first,
    input  t_body            i_second,
    input  logic [THR_W-1:0] i_thr,
    output t_pair            o_pair
);

    logic signed [COORD_W-1:0] pa [3];
    logic signed [COORD_W-1:0] pb [3];
    logic signed [COORD_W-1:0] va [3];
    logic signed [COORD_W-1:0] vb [3];
    logic [EXT_W-1:0]          ea [3];
    logic [EXT_W-1:0]          eb [3];

    logic signed [OVL_W-1:0]   lowov  [3];
    logic signed [OVL_W-1:0]   highov [3];
    logic signed [OVL_W-1:0]   mn     [3];
    logic [COORD_W:0]          vsum   [3];

    logic signed [COORD_W-1:0] npa [3];
    logic signed [COORD_W-1:0] npb [3];
    logic signed [COORD_W-1:0] nva [3];
    logic signed [COORD_W-1:0] nvb [3];

    logic                    hit;
    logic [AXIS_W-1:0]       axis_min;
    logic [AXIS_W-1:0]       axis_vel;
    logic [AXIS_W-1:0]       axis;
    logic signed [OVL_W-1:0] ov_run;
    logic signed [OVL_W:0]   d01;
    logic signed [OVL_W:0]   d02;
    logic [OVL_W:0]          a01;
    logic [OVL_W:0]          a02;
    logic                    tie;
    logic signed [OVL_W-1:0] ov;
    logic signed [OVL_W-1:0] half;
    logic                    a_down;
    logic signed [OVL_W-1:0] da;
    logic signed [OVL_W-1:0] db;
    logic signed [COORD_W:0] nega;
    logic signed [COORD_W:0] negb;
    logic signed [WIDE_W-1:0] proda;
    logic signed [WIDE_W-1:0] prodb;
    logic signed [COORD_W-1:0] bva;
    logic signed [COORD_W-1:0] bvb;
    logic signed [COORD_W-1:0] va_sel;
    logic signed [COORD_W-1:0] vb_sel;

    always_comb begin
        pa[0] = i_first.pos_x;  pa[1] = i_first.pos_y;  pa[2] = i_first.pos_z;
        va[0] = i_first.vel_x;  va[1] = i_first.vel_y;  va[2] = i_first.vel_z;
        ea[0] = i_first.extent_xz; ea[1] = i_first.extent_y; ea[2] = i_first.extent_xz;
        pb[0] = i_second.pos_x; pb[1] = i_second.pos_y; pb[2] = i_second.pos_z;
        vb[0] = i_second.vel_x; vb[1] = i_second.vel_y; vb[2] = i_second.vel_z;
        eb[0] = i_second.extent_xz; eb[1] = i_second.extent_y;
        eb[2] = i_second.extent_xz;
    end

    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            lowov[i]  = $signed({{2{pa[i][COORD_W-1]}}, pa[i]})
                      + $signed({3'b000, ea[i]})
                      - $signed({{2{pb[i][COORD_W-1]}}, pb[i]});
            highov[i] = $signed({{2{pb[i][COORD_W-1]}}, pb[i]})
                      + $signed({3'b000, eb[i]})
                      - $signed({{2{pa[i][COORD_W-1]}}, pa[i]});
            if (lowov[i][OVL_W-1] || highov[i][OVL_W-1]) begin
                hit = 1'b0;
            end
            mn[i] = (lowov[i] < highov[i]) ? lowov[i] : highov[i];
            vsum[i] = {1'b0, (va[i][COORD_W-1] ? -va[i] : va[i])}
                    + {1'b0, (vb[i][COORD_W-1] ? -vb[i] : vb[i])};
        end
    end

    // least penetration, ties to the lower axis
    always_comb begin
        axis_min = AXIS_X;
        ov_run   = mn[0];
        if (mn[1] < ov_run) begin
            axis_min = AXIS_Y;
            ov_run   = mn[1];
        end
        if (mn[2] < ov_run) begin
            axis_min = AXIS_Z;
        end
    end

    always_comb begin
        d01 = $signed({mn[0][OVL_W-1], mn[0]}) - $signed({mn[1][OVL_W-1], mn[1]});
        d02 = $signed({mn[0][OVL_W-1], mn[0]}) - $signed({mn[2][OVL_W-1], mn[2]});
        a01 = d01[OVL_W] ? -d01 : d01;
        a02 = d02[OVL_W] ? -d02 : d02;
        tie = (a01 < {{(OVL_W+1-THR_W){1'b0}}, i_thr})
           && (a02 < {{(OVL_W+1-THR_W){1'b0}}, i_thr});
        if (vsum[0] >= vsum[1] && vsum[0] >= vsum[2]) begin
            axis_vel = AXIS_X;
        end else if (vsum[1] >= vsum[2]) begin
            axis_vel = AXIS_Y;
        end else begin
            axis_vel = AXIS_Z;
        end
        axis = tie ? axis_vel : axis_min;
    end

    always_comb begin
        case (axis)
            AXIS_Y: begin
                ov     = mn[1];
                a_down = lowov[1] < highov[1];
                va_sel = va[1];
                vb_sel = vb[1];
            end
            AXIS_Z: begin
                ov     = mn[2];
                a_down = lowov[2] < highov[2];
                va_sel = va[2];
                vb_sel = vb[2];
            end
            default: begin
                ov     = mn[0];
                a_down = lowov[0] < highov[0];
                va_sel = va[0];
                vb_sel = vb[0];
            end
        endcase
        half = ov >>> 1;
        if (i_first.fixed) begin
            da = '0;
            db = a_down ? ov : -ov;
        end else if (i_second.fixed) begin
            da = a_down ? -ov : ov;
            db = '0;
        end else begin
            da = a_down ? -half : half;
            db = a_down ? half : -half;
        end
    end

    // bounce: floor(-v * r / 256), saturated
    always_comb begin
        nega  = -$signed({va_sel[COORD_W-1], va_sel});
        negb  = -$signed({vb_sel[COORD_W-1], vb_sel});
        proda = WIDE_W'(nega) * WIDE_W'($signed({1'b0, i_first.restitution}));
        prodb = WIDE_W'(negb) * WIDE_W'($signed({1'b0, i_second.restitution}));
        bva   = sat_coord(proda >>> REST_FRAC);
        bvb   = sat_coord(prodb >>> REST_FRAC);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            npa[i] = pa[i];
            npb[i] = pb[i];
            nva[i] = va[i];
            nvb[i] = vb[i];
            if (hit && axis == AXIS_W'(i)) begin
                npa[i] = sat_coord(WIDE_W'(pa[i]) + WIDE_W'(da));
                npb[i] = sat_coord(WIDE_W'(pb[i]) + WIDE_W'(db));
                if (!i_first.fixed) begin
                    nva[i] = bva;
                end
                if (!i_second.fixed) begin
                    nvb[i] = bvb;
                end
            end
        end
    end

    always_comb begin
        o_pair.beat0.body_index = 1'b0;
        o_pair.beat0.collided   = hit;
        o_pair.beat0.new_pos_x  = npa[0];
        o_pair.beat0.new_pos_y  = npa[1];
        o_pair.beat0.new_pos_z  = npa[2];
        o_pair.beat0.new_vel_x  = nva[0];
        o_pair.beat0.new_vel_y  = nva[1];
        o_pair.beat0.new_vel_z  = nva[2];
        o_pair.beat0.last       = 1'b0;
        o_pair.beat1.body_index = 1'b1;
        o_pair.beat1.collided   = hit;
        o_pair.beat1.new_pos_x  = npb[0];
        o_pair.beat1.new_pos_y  = npb[1];
        o_pair.beat1.new_pos_z  = npb[2];
        o_pair.beat1.new_vel_x  = nvb[0];
        o_pair.beat1.new_vel_y  = nvb[1];
        o_pair.beat1.new_vel_z  = nvb[2];
        o_pair.beat1.last       = 1'b1;
    end

endmodule

>>> rtl/acr3d_out_buf.sv
// ----------------------------------------------------------------------------
// acr3d_out_buf
// Result register: holds one resolved pair and sends it as two beats.
// ----------------------------------------------------------------------------
module acr3d_out_buf
    import acr3d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_pair     i_pair,
    output logic      o_can_load,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    logic  r_full;
    logic  r_beat;
    t_pair r_pair;

    assign o_can_load = !r_full || (r_beat && i_ready);
    assign o_valid    = r_full;
    assign o_data     = r_beat ? r_pair.beat1 : r_pair.beat0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_beat <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
            r_beat <= 1'b0;
        end else if (r_full && i_ready) begin
            if (r_beat) begin
                r_full <= 1'b0;
            end else begin
                r_beat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pair <= i_pair;
        end
    end

endmodule

>>> rtl/aabb_collision_resolver_3d_unit.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolver_3d_unit
// Resolves a collision between two axis-aligned boxes in Q15.8 fixed point.
// ----------------------------------------------------------------------------
// A load beat (operation 0) stores the first body and produces no result; a
// resolve beat (operation 1) brings the second body and produces two result
// beats, first body then second body. Input beats are taken one per cycle
// while the result register keeps up; a resolve beat is registered, resolved
// in one combinational pass and its pair is loaded into the result register
// once that register can take it, which then presents the first result beat.
// The result register drives one beat per cycle while the receiver is ready,
// and a new pair can be loaded as the second beat of the last one is taken.
// tie_threshold resets to 5.0 and is written through the cfg channel; the user
// must write it only while idle, as the block itself does not enforce it.
module aabb_collision_resolver_3d_unit
    import acr3d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [THR_W-1:0] i_cfg_data
);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(5 << FRAC_BITS);

    logic             r_a_valid;
    logic             n_a_valid;
    t_body            r_a_second;
    t_body            r_a_first;
    t_body            r_first;
    logic [THR_W-1:0] r_thr;
    logic             in_acc;
    logic             can_load;
    t_pair            pair;

    assign o_in_ready  = !r_a_valid || can_load;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_acc && i_in_data.operation == OP_RESOLVE) begin
            n_a_valid = 1'b1;
        end else if (can_load) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_first   <= '0;
            r_thr     <= THR_RESET;
        end else begin
            r_a_valid <= n_a_valid;
            if (in_acc && i_in_data.operation == OP_LOAD) begin
                r_first <= body_of(i_in_data);
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // snapshot of the stored body travels with the pair
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.operation == OP_RESOLVE) begin
            r_a_second <= body_of(i_in_data);
            r_a_first  <= r_first;
        end
    end

    acr3d_resolve u_resolve (
        .i_first  (r_a_first),
        .i_second (r_a_second),
        .i_thr    (r_thr),
        .o_pair   (pair)
    );

    acr3d_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_a_valid && can_load),
        .i_pair     (pair),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last)
        |=> (o_out_valid && o_out_data.last && o_out_data.body_index))
        else $error("second result beat did not follow the first");

    a_pair_collided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last)
        |=> (o_out_data.collided == $past(o_out_data.collided)))
        else $error("collided differs between the two beats of a pair");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !can_load) |=> (r_a_valid && $stable(r_a_second)))
        else $error("pending pair lost while result register busy");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.operation == OP_LOAD && !r_a_valid && !o_out_valid)
        |=> !r_a_valid)
        else $error("load beat produced a pending result");

endmodule
